/* hdl/pdpc_pkg.sv */
// Shared types, constants and helper functions for the packet deframer with ones-count check.
// Used by every module of the block; has no dependencies of its own.
package pdpc_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
    localparam logic [7:0] MIN_LENGTH = 8'd5;

    localparam logic [HDR_IDX_W-1:0] HDR_COUNT_HI = HDR_IDX_W'(0);
    localparam logic [HDR_IDX_W-1:0] HDR_COUNT_LO = HDR_IDX_W'(1);
    localparam logic [HDR_IDX_W-1:0] HDR_FLAGS    = HDR_IDX_W'(2);
    localparam logic [HDR_IDX_W-1:0] HDR_LENGTH   = HDR_IDX_W'(3);

    localparam logic [7:0] FLAG_DRIVE    = 8'h80;
    localparam logic [7:0] FLAG_RESPONSE = 8'h40;
    localparam logic [7:0] FLAG_SLEEP    = 8'h20;
    localparam logic [7:0] FLAG_ACK      = 8'h10;

    localparam logic [1:0] CMD_DRIVE    = 2'd0;
    localparam logic [1:0] CMD_RESPONSE = 2'd1;
    localparam logic [1:0] CMD_SLEEP    = 2'd2;

    localparam logic KIND_BODY   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  body_byte;
        logic [15:0] packet_count;
        logic [1:0]  command;
        logic        ack_flag;
        logic [7:0]  packet_length;
        logic        check_ok;
        logic        length_error;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [3:0] ones_count(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

    function automatic logic [1:0] decode_command(input logic [7:0] flags);
        logic [1:0] cmd;
        priority if ((flags & FLAG_DRIVE) != 8'h00)
        begin
            cmd = CMD_DRIVE;
        end
        else if ((flags & FLAG_RESPONSE) != 8'h00)
        begin
            cmd = CMD_RESPONSE;
        end
        else if ((flags & FLAG_SLEEP) != 8'h00)
        begin
            cmd = CMD_SLEEP;
        end
        else
        begin
            cmd = CMD_RESPONSE;
        end
        return cmd;
    endfunction

    function automatic result_t make_report(input logic [7:0] cnt_hi, input logic [7:0] cnt_lo,
                                            input logic [7:0] flags, input logic [7:0] length,
                                            input logic ok, input logic len_err);
        result_t r;
        r.result_kind   = KIND_REPORT;
        r.body_byte     = 8'd0;
        r.packet_count  = {cnt_hi, cnt_lo};
        r.command       = decode_command(flags);
        r.ack_flag      = (flags & FLAG_ACK) != 8'h00;
        r.packet_length = length;
        r.check_ok      = ok;
        r.length_error  = len_err;
        return r;
    endfunction

endpackage

/* hdl/packet_deframer_popcount_check_top.sv */
// Top level of the packet deframer with ones-count check.
// Depends on pdpc_pkg and instantiates pdpc_front, pdpc_fifo and pdpc_back.
//
// Input channel: one packet byte per beat on rx_byte, taken when in_valid is high and
// in_stall is low. The first four bytes of a packet are the header (count high, count
// low, flags, total length); the block forwards each body byte as a result beat and ends
// the packet with one report beat carrying the count, command, ack flag, length and the
// outcome of the ones-count check. Header bytes give no beat unless the length is bad.
// Output channel: out_valid with out_stall from the receiver; a beat is taken when
// out_valid is high and out_stall is low, and a stalled beat holds its value.
// A result passes through the queue and then the output register before it reaches the output.
// Throughput: one byte per cycle while in_stall is low, set by the ones count and accumulate in
// the front end. A four-entry queue sits between the front end and the output register,
// so the input keeps flowing while the receiver stalls until the queue fills; in_stall
// then follows the queue's full flag.
// Reset clears the packet position, header fields, running count, queue and output valid.
module packet_deframer_popcount_check_top
    import pdpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [7:0]  body_byte,
    output logic [15:0] packet_count,
    output logic [1:0]  command,
    output logic        ack_flag,
    output logic [7:0]  packet_length,
    output logic        check_ok,
    output logic        length_error
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    result_t   push_data;
    result_t   pop_data;
    result_t   out_data;

    pdpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    pdpc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    pdpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign result_kind   = out_data.result_kind;
    assign body_byte     = out_data.body_byte;
    assign packet_count  = out_data.packet_count;
    assign command       = out_data.command;
    assign ack_flag      = out_data.ack_flag;
    assign packet_length = out_data.packet_length;
    assign check_ok      = out_data.check_ok;
    assign length_error  = out_data.length_error;

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty at once");

    a_body_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_BODY |->
            packet_count == 16'd0 && command == CMD_DRIVE && !ack_flag &&
            packet_length == 8'd0 && !check_ok && !length_error)
        else $error("body beat carries report fields");

    a_len_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_REPORT && length_error |->
            !check_ok && packet_length < MIN_LENGTH)
        else $error("length error report inconsistent");

    a_len_good: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_REPORT && !length_error |->
            packet_length >= MIN_LENGTH)
        else $error("check report with short length");

endmodule

/* hdl/pdpc_front.sv */
// Front end: accepts packet bytes, tracks the header and the ones count, and classifies each beat.
// Depends on pdpc_pkg; pushes results into the queue in pdpc_fifo.
module pdpc_front
    import pdpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic [7:0] rx_byte,
    input  q_status_t q_status,
    output logic      push,
    output result_t   push_data
);

    logic [7:0] pos_reg, pos_next;
    logic [7:0] count_hi_reg, count_hi_next;
    logic [7:0] count_lo_reg, count_lo_next;
    logic [7:0] flags_reg, flags_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] ones_reg, ones_next;
    logic       accept;
    logic [7:0] ones_add;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;
    assign ones_add = ones_reg + {4'd0, ones_count(rx_byte)};

    always_comb
    begin
        pos_next      = pos_reg;
        count_hi_next = count_hi_reg;
        count_lo_next = count_lo_reg;
        flags_next    = flags_reg;
        length_next   = length_reg;
        ones_next     = ones_reg;
        push          = 1'b0;
        push_data     = '0;
        if (accept)
        begin
            if (pos_reg < 8'(HEADER_BYTES))
            begin
                unique case (pos_reg[HDR_IDX_W-1:0])
                    HDR_COUNT_HI: count_hi_next = rx_byte;
                    HDR_COUNT_LO: count_lo_next = rx_byte;
                    HDR_FLAGS:    flags_next    = rx_byte;
                    HDR_LENGTH:   length_next   = rx_byte;
                endcase
                if (pos_reg[HDR_IDX_W-1:0] == HDR_LENGTH && rx_byte < MIN_LENGTH)
                begin
                    push      = 1'b1;
                    push_data = make_report(count_hi_reg, count_lo_reg, flags_reg, rx_byte,
                                            1'b0, 1'b1);
                    pos_next  = 8'd0;
                    ones_next = 8'd0;
                end
                else
                begin
                    pos_next  = pos_reg + 8'd1;
                    ones_next = ones_add;
                end
            end
            else if ({1'b0, pos_reg} + 9'd1 >= {1'b0, length_reg})
            begin
                push      = 1'b1;
                push_data = make_report(count_hi_reg, count_lo_reg, flags_reg, length_reg,
                                        rx_byte == ones_reg, 1'b0);
                pos_next  = 8'd0;
                ones_next = 8'd0;
            end
            else
            begin
                push                  = 1'b1;
                push_data.result_kind = KIND_BODY;
                push_data.body_byte   = rx_byte;
                pos_next              = pos_reg + 8'd1;
                ones_next             = ones_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 8'd0;
            count_hi_reg <= 8'd0;
            count_lo_reg <= 8'd0;
            flags_reg    <= 8'd0;
            length_reg   <= 8'd0;
            ones_reg     <= 8'd0;
        end
        else
        begin
            pos_reg      <= pos_next;
            count_hi_reg <= count_hi_next;
            count_lo_reg <= count_lo_next;
            flags_reg    <= flags_next;
            length_reg   <= length_next;
            ones_reg     <= ones_next;
        end
    end

endmodule

/* hdl/pdpc_fifo.sv */
// Short result queue between the front end and the output stage.
// Depends on pdpc_pkg for the result type and the queue depth.
module pdpc_fifo
    import pdpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  result_t   push_data,
    input  logic      pop,
    output result_t   pop_data,
    output q_status_t q_status
);

    result_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign do_push = push && (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    assign q_status.full  = count_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign q_status.empty = count_reg == '0;
    assign pop_data       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/pdpc_back.sv */
// Back end: pops queued results into the output register and hands them to the receiver.
// Depends on pdpc_pkg for the result and queue status types.
module pdpc_back
    import pdpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_status,
    input  result_t   pop_data,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output result_t   out_data
);

    result_t out_reg;
    logic    valid_reg, valid_next;

    assign pop       = !q_status.empty && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= pop_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

/* tb/sv/packet_deframer_popcount_check_top_tb.sv */
// Self-checking testbench for packet_deframer_popcount_check_top: directed and random packets
// drive the byte channel and each output beat is checked against a built-in deframer model.
// Depends on pdpc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module packet_deframer_popcount_check_top_tb;
    import pdpc_pkg::*;

    localparam int HOLD_CYCLES = 80;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        result_kind;
    logic [7:0]  body_byte;
    logic [15:0] packet_count;
    logic [1:0]  command;
    logic        ack_flag;
    logic [7:0]  packet_length;
    logic        check_ok;
    logic        length_error;

    logic [7:0]  pending_bytes[$];
    result_t     expected_beats[$];

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_toggle = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int          fail_count = 0;

    logic [7:0]  rx_pos = 8'h00;
    logic [7:0]  hdr_count_hi = 8'h00;
    logic [7:0]  hdr_count_lo = 8'h00;
    logic [7:0]  hdr_flags = 8'h00;
    logic [7:0]  hdr_length = 8'h00;
    logic [7:0]  ones_total = 8'h00;

    packet_deframer_popcount_check_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .body_byte     (body_byte),
        .packet_count  (packet_count),
        .command       (command),
        .ack_flag      (ack_flag),
        .packet_length (packet_length),
        .check_ok      (check_ok),
        .length_error  (length_error)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic deframe_byte(input logic [7:0] b);
        result_t r;
        logic    emit;
        logic    is_report;
        logic    ok;
        logic    len_err;
        r = '0;
        emit = 1'b0;
        is_report = 1'b0;
        ok = 1'b0;
        len_err = 1'b0;
        if (rx_pos < 8'(HEADER_BYTES))
        begin
            if (rx_pos == 8'(HDR_COUNT_HI))
                hdr_count_hi = b;
            else if (rx_pos == 8'(HDR_COUNT_LO))
                hdr_count_lo = b;
            else if (rx_pos == 8'(HDR_FLAGS))
                hdr_flags = b;
            else
                hdr_length = b;
            ones_total = ones_total + 8'($countones(b));
            if (rx_pos == 8'(HDR_LENGTH) && hdr_length < MIN_LENGTH)
            begin
                is_report = 1'b1;
                len_err = 1'b1;
            end
            else
            begin
                rx_pos = rx_pos + 8'd1;
            end
        end
        else if ({1'b0, rx_pos} + 9'd1 >= {1'b0, hdr_length})
        begin
            is_report = 1'b1;
            ok = (b == ones_total);
        end
        else
        begin
            ones_total = ones_total + 8'($countones(b));
            rx_pos = rx_pos + 8'd1;
            r.result_kind = KIND_BODY;
            r.body_byte = b;
            emit = 1'b1;
        end
        if (is_report)
        begin
            r.result_kind = KIND_REPORT;
            r.packet_count = {hdr_count_hi, hdr_count_lo};
            if ((hdr_flags & FLAG_DRIVE) != 8'h00)
                r.command = CMD_DRIVE;
            else if ((hdr_flags & FLAG_RESPONSE) != 8'h00)
                r.command = CMD_RESPONSE;
            else if ((hdr_flags & FLAG_SLEEP) != 8'h00)
                r.command = CMD_SLEEP;
            else
                r.command = CMD_RESPONSE;
            r.ack_flag = (hdr_flags & FLAG_ACK) != 8'h00;
            r.packet_length = hdr_length;
            r.check_ok = ok;
            r.length_error = len_err;
            rx_pos = 8'h00;
            ones_total = 8'h00;
            emit = 1'b1;
        end
        if (emit)
            expected_beats.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'h00;
            rx_pos = 8'h00;
            hdr_count_hi = 8'h00;
            hdr_count_lo = 8'h00;
            hdr_flags = 8'h00;
            hdr_length = 8'h00;
            ones_total = 8'h00;
        end
        else
        begin
            if (in_valid && !in_stall)
                deframe_byte(rx_byte);
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte <= pending_bytes.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_beat
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{result_kind, body_byte, packet_count, command, ack_flag,
                    packet_length, check_ok, length_error};
            if (expected_beats.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected beat kind=%0d body=%02h count=%04h cmd=%0d",
                             $time, got.result_kind, got.body_byte, got.packet_count,
                             got.command);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: beat mismatch", $time);
                        $display("  exp k=%0d b=%02h c=%04h cmd=%0d a=%0d l=%0d ok=%0d le=%0d",
                                 want.result_kind, want.body_byte, want.packet_count,
                                 want.command, want.ack_flag, want.packet_length,
                                 want.check_ok, want.length_error);
                        $display("  act k=%0d b=%02h c=%04h cmd=%0d a=%0d l=%0d ok=%0d le=%0d",
                                 got.result_kind, got.body_byte, got.packet_count,
                                 got.command, got.ack_flag, got.packet_length,
                                 got.check_ok, got.length_error);
                    end
                end
            end
        end
    end

    task automatic push_packet(input logic [15:0] cnt, input logic [7:0] flags,
                               input logic [7:0] len, input logic corrupt,
                               input logic fill_random, input logic [7:0] fill);
        logic [7:0] b;
        logic [7:0] chk;
        int         i;
        chk = 8'($countones(cnt) + $countones(flags) + $countones(len));
        pending_bytes.push_back(cnt[15:8]);
        pending_bytes.push_back(cnt[7:0]);
        pending_bytes.push_back(flags);
        pending_bytes.push_back(len);
        if (len >= MIN_LENGTH)
        begin
            for (i = 0; i < int'(len - MIN_LENGTH); i++)
            begin
                b = fill_random ? 8'($urandom) : fill;
                chk = chk + 8'($countones(b));
                pending_bytes.push_back(b);
            end
            pending_bytes.push_back(corrupt ? chk ^ 8'($urandom_range(1, 255)) : chk);
        end
    endtask

    task automatic random_traffic(input int n_items);
        int         sent;
        int         pick;
        int         n;
        logic [7:0] len;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                n = $urandom_range(1, 6);
                repeat (n) pending_bytes.push_back(8'($urandom));
                sent += n;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    len = 8'($urandom_range(0, 4));
                else if (pick < 13)
                    len = 8'($urandom_range(17, 255));
                else
                    len = 8'($urandom_range(5, 16));
                push_packet(16'($urandom), 8'($urandom), len, $urandom_range(4) == 0,
                            1'b1, 8'h00);
                sent += (len < MIN_LENGTH) ? HEADER_BYTES : int'(len);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge clk);
        send_idle_pct <= send_pct;
        stall_pct <= recv_pct;
    endtask

    initial
    begin
        int k;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed packets: every command, ack, good and bad checks, short lengths.
        push_packet(16'h0000, 8'hFF, 8'd5, 1'b0, 1'b0, 8'h00);
        push_packet(16'h1234, 8'h40, 8'd4, 1'b0, 1'b0, 8'h00);
        push_packet(16'hFFFF, 8'h20, 8'd0, 1'b0, 1'b0, 8'h00);
        push_packet(16'h8001, 8'h10, 8'd6, 1'b0, 1'b0, 8'hFF);
        push_packet(16'h00FF, 8'h60, 8'd6, 1'b1, 1'b0, 8'h00);
        wait_drained();

        // The receiver holds off while a long packet keeps the sender busy.
        @(posedge clk);
        hold_toggle <= ~hold_toggle;
        push_packet(16'hA5C3, 8'h90, 8'd40, 1'b0, 1'b0, 8'hFF);
        wait_drained();

        random_traffic(80);
        wait_drained();
        set_idling(67, 0);
        random_traffic(80);
        wait_drained();
        set_idling(0, 67);
        random_traffic(80);
        wait_drained();
        set_idling(33, 33);
        random_traffic(80);
        wait_drained();

        for (k = 0; k < 5000 && expected_beats.size() != 0; k++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (expected_beats.size() != 0)
        begin
            fail_count++;
            $display("%0d expected beats never arrived", expected_beats.size());
        end
        if (fail_count == 0)
            $display("** packet_deframer_popcount_check_top: PASSED **");
        else
            $display("** packet_deframer_popcount_check_top: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout: the run did not finish in time.");
        $display("** packet_deframer_popcount_check_top: FAILED **");
        $finish;
    end

endmodule
